// ===== rtl/core/irbst_pkg.sv =====
// ----------------------------------------------------------------------------
// irbst_pkg
// shared types, codes and constants of the infrared burst sequence transmitter
// ----------------------------------------------------------------------------
package irbst_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MAX_LEN         = 256;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;
    localparam int S_DATA_W        = 24;
    localparam int S_USER_W        = 2;
    localparam int M_DATA_W        = 8;
    localparam int ENTRY_W         = 16;
    localparam int IDX_W           = 8;
    localparam int LEN_W           = 9;
    localparam int HPL_W           = 17;

    localparam logic [15:0] HALF_PERIOD_RST  = 16'd13;
    localparam logic [8:0]  SEQ_LENGTH_RST   = 9'd2;
    localparam logic [15:0] REPEAT_TOTAL_RST = 16'd1;
    localparam logic [7:0]  REPEAT_START_RST = 8'd0;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_HALF_PERIOD  = 3'd0,
        REG_SEQ_LENGTH   = 3'd1,
        REG_REPEAT_TOTAL = 3'd2,
        REG_REPEAT_START = 3'd3,
        REG_ACTIVE_LOW   = 3'd4
    } t_reg;

    typedef struct packed {
        logic [15:0] half_period;
        logic [8:0]  seq_length;
        logic [15:0] repeat_total;
        logic [7:0]  repeat_start;
        logic        active_low;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_GAP,
        S_GAP_WAIT,
        S_ADVANCE,
        S_BOUNDARY,
        S_RD_BURST,
        S_BURST_WAIT,
        S_RD_LGAP,
        S_LGAP_WAIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic latch;
        logic wr;
        logic start;
        logic stop;
        logic tick;
        logic rd_en;
        logic rd_gap;
        logic set_burst;
        logic set_gap;
        logic advance;
        logic boundary;
        logic capture;
    } t_dp_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic running;
        logic len_zero;
        logic hpl_zero;
        logic tick_end;
        logic in_burst;
        logic rd_zero;
        logic bound_end;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/irbst_ram.sv =====
// ----------------------------------------------------------------------------
// irbst_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module irbst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/irbst_regs.sv =====
// ----------------------------------------------------------------------------
// irbst_regs
// apb configuration registers
// ----------------------------------------------------------------------------
module irbst_regs
    import irbst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_reg sel_reg;
    logic wr_stb;

    assign sel_reg = t_reg'(paddr[4:2]);
    assign wr_stb  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period  <= HALF_PERIOD_RST;
            r_cfg.seq_length   <= SEQ_LENGTH_RST;
            r_cfg.repeat_total <= REPEAT_TOTAL_RST;
            r_cfg.repeat_start <= REPEAT_START_RST;
            r_cfg.active_low   <= 1'b0;
        end else if (wr_stb) begin
            unique case (sel_reg)
                REG_HALF_PERIOD:  r_cfg.half_period  <= pwdata[15:0];
                REG_SEQ_LENGTH:   r_cfg.seq_length   <= pwdata[8:0];
                REG_REPEAT_TOTAL: r_cfg.repeat_total <= pwdata[15:0];
                REG_REPEAT_START: r_cfg.repeat_start <= pwdata[7:0];
                REG_ACTIVE_LOW:   r_cfg.active_low   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (sel_reg)
            REG_HALF_PERIOD:  prdata = {16'd0, r_cfg.half_period};
            REG_SEQ_LENGTH:   prdata = {23'd0, r_cfg.seq_length};
            REG_REPEAT_TOTAL: prdata = {16'd0, r_cfg.repeat_total};
            REG_REPEAT_START: prdata = {24'd0, r_cfg.repeat_start};
            REG_ACTIVE_LOW:   prdata = {31'd0, r_cfg.active_low};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/irbst_dp.sv =====
// ----------------------------------------------------------------------------
// irbst_dp
// datapath: item latch, carrier timing counters, pair sequencing, result register
// ----------------------------------------------------------------------------
module irbst_dp
    import irbst_pkg::*;
#(
    parameter int  TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_ctrl            i_ctl,
    output t_dp_stat            o_stat,
    input  t_cfg                i_cfg,
    input  logic [S_DATA_W-1:0] i_s_data,
    input  logic [S_USER_W-1:0] i_s_user,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output logic [M_DATA_W-1:0] o_m_data,
    output logic                o_m_last,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [ENTRY_W-1:0]  o_wr_data,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  logic [ENTRY_W-1:0]  i_rd_data
);

    localparam logic [LEN_W-1:0] LEN_CAP = (TABLE_DEPTH >= MAX_LEN) ?
        LEN_W'(MAX_LEN) : LEN_W'(TABLE_DEPTH & ~1);

    // latched item
    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_idx;
    logic [ENTRY_W-1:0] r_val;

    logic [LEN_W-1:0]   r_pair, n_pair;
    logic [15:0]        r_htc, n_htc;
    logic [HPL_W-1:0]   r_hpl, n_hpl;
    logic               r_in_burst, n_in_burst;
    logic               r_level, n_level;
    logic               r_rep_mode, n_rep_mode;
    logic [15:0]        r_reps, n_reps;
    logic               r_running, n_running;
    logic               r_stop, n_stop;
    logic               r_done, n_done;

    logic               r_out_valid;
    logic               r_out_level;
    logic               r_out_busy;
    logic               r_out_done;

    logic [LEN_W-1:0]   len_even;
    logic [LEN_W-1:0]   used_len;
    logic [LEN_W-1:0]   rs_ext;
    logic [15:0]        hp;
    logic               wrap;
    logic [HPL_W-1:0]   hpl_dec;
    logic [HPL_W-1:0]   tick_hpl;
    logic               past_end;
    logic               bound_end;
    logic               fin;
    logic [7:0]         rd_idx;
    logic [AW+7:0]      rd_ext;
    logic [AW+7:0]      wr_ext;

    assign len_even = {i_cfg.seq_length[8:1], 1'b0};
    assign used_len = (len_even > LEN_CAP) ? LEN_CAP : len_even;
    assign rs_ext   = {1'b0, i_cfg.repeat_start[7:1], 1'b0};
    assign hp       = (i_cfg.half_period == '0) ? 16'd1 : i_cfg.half_period;
    assign wrap     = ({1'b0, r_htc} + 17'd1) >= {1'b0, hp};
    assign hpl_dec  = r_hpl - HPL_W'(1);
    assign tick_hpl = wrap ? hpl_dec : r_hpl;
    assign past_end = r_pair >= used_len;
    assign bound_end = r_stop ||
        (past_end && ((rs_ext >= used_len) || (!r_rep_mode && (r_reps == '0))));

    // table addressing
    assign rd_idx    = i_ctl.rd_gap ? {r_pair[7:1], 1'b1} : r_pair[7:0];
    assign rd_ext    = {{AW{1'b0}}, rd_idx};
    assign wr_ext    = {{AW{1'b0}}, r_idx};
    assign o_rd_en   = i_ctl.rd_en;
    assign o_rd_addr = rd_ext[AW-1:0];
    assign o_wr_en   = i_ctl.wr && (int'(r_idx) < TABLE_DEPTH);
    assign o_wr_addr = wr_ext[AW-1:0];
    assign o_wr_data = r_val;

    always_comb begin
        n_pair     = r_pair;
        n_htc      = r_htc;
        n_hpl      = r_hpl;
        n_in_burst = r_in_burst;
        n_level    = r_level;
        n_rep_mode = r_rep_mode;
        n_reps     = r_reps;
        n_running  = r_running;
        n_stop     = r_stop;
        n_done     = r_done;
        fin        = 1'b0;

        if (i_ctl.latch) begin
            n_done = 1'b0;
        end
        if (i_ctl.start) begin
            n_running  = 1'b1;
            n_stop     = 1'b0;
            n_pair     = '0;
            n_rep_mode = (i_cfg.repeat_total == '0);
            n_reps     = (i_cfg.repeat_total == '0) ? '0 : i_cfg.repeat_total - 16'd1;
            fin        = (used_len == '0);
        end
        if (i_ctl.stop && r_running) begin
            n_stop = 1'b1;
        end
        if (i_ctl.tick) begin
            if (wrap) begin
                n_htc = '0;
                n_hpl = hpl_dec;
            end else begin
                n_htc = r_htc + 16'd1;
            end
            if ((tick_hpl == '0) && r_in_burst) begin
                n_in_burst = 1'b0;
                n_level    = 1'b0;
            end else if (wrap && r_in_burst) begin
                n_level = !r_level;
            end
        end
        if (i_ctl.set_burst) begin
            n_htc = '0;
            if (i_rd_data != '0) begin
                n_in_burst = 1'b1;
                n_level    = 1'b1;
                n_hpl      = {i_rd_data, 1'b0};
            end else begin
                n_in_burst = 1'b0;
                n_level    = 1'b0;
            end
        end
        if (i_ctl.set_gap) begin
            n_hpl = {i_rd_data, 1'b0};
        end
        if (i_ctl.advance) begin
            n_pair = r_pair + LEN_W'(2);
        end
        if (i_ctl.boundary) begin
            if (bound_end) begin
                fin = 1'b1;
            end else if (past_end) begin
                n_pair = rs_ext;
                if (!r_rep_mode) begin
                    n_reps = r_reps - 16'd1;
                end
            end
        end
        if (fin) begin
            n_running  = 1'b0;
            n_stop     = 1'b0;
            n_in_burst = 1'b0;
            n_level    = 1'b0;
            n_hpl      = '0;
            n_htc      = '0;
            n_done     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair      <= '0;
            r_htc       <= '0;
            r_hpl       <= '0;
            r_in_burst  <= 1'b0;
            r_level     <= 1'b0;
            r_rep_mode  <= 1'b0;
            r_reps      <= '0;
            r_running   <= 1'b0;
            r_stop      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pair     <= n_pair;
            r_htc      <= n_htc;
            r_hpl      <= n_hpl;
            r_in_burst <= n_in_burst;
            r_level    <= n_level;
            r_rep_mode <= n_rep_mode;
            r_reps     <= n_reps;
            r_running  <= n_running;
            r_stop     <= n_stop;
            r_done     <= n_done;
            if (i_ctl.capture) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd <= t_cmd'(i_s_user);
            r_idx <= i_s_data[7:0];
            r_val <= i_s_data[23:8];
        end
        if (i_ctl.capture) begin
            r_out_level <= r_level ^ i_cfg.active_low;
            r_out_busy  <= r_running;
            r_out_done  <= r_done;
        end
    end

    assign o_stat.cmd       = r_cmd;
    assign o_stat.running   = r_running;
    assign o_stat.len_zero  = (used_len == '0);
    assign o_stat.hpl_zero  = (r_hpl == '0);
    assign o_stat.tick_end  = (tick_hpl == '0);
    assign o_stat.in_burst  = r_in_burst;
    assign o_stat.rd_zero   = (i_rd_data == '0);
    assign o_stat.bound_end = bound_end;
    assign o_stat.out_free  = !r_out_valid || i_m_ready;

    assign o_m_valid = r_out_valid;
    assign o_m_data  = {6'd0, r_out_busy, r_out_level};
    assign o_m_last  = r_out_done;

`ifndef SYNTHESIS
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_hpl == '0) && !r_in_burst && !r_level)
        else $error("idle transmitter holds timing state");

    a_burst_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_burst |-> (r_hpl != '0))
        else $error("burst active with no half periods left");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> !r_out_busy)
        else $error("finished result reports busy");
`endif

endmodule

// ===== rtl/core/irbst_ctrl.sv =====
// ----------------------------------------------------------------------------
// irbst_ctrl
// controller state machine sequencing one transaction through the datapath
// ----------------------------------------------------------------------------
module irbst_ctrl
    import irbst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    output logic     o_s_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (i_stat.cmd)
                    CMD_START: begin
                        n_state = (!i_stat.running && !i_stat.len_zero) ? S_RD_BURST
                                                                        : S_RESULT;
                    end
                    CMD_TICK: begin
                        if (!i_stat.running) begin
                            n_state = S_RESULT;
                        end else if (i_stat.hpl_zero) begin
                            n_state = S_ADVANCE;
                        end else if (!i_stat.tick_end) begin
                            n_state = S_RESULT;
                        end else if (i_stat.in_burst) begin
                            n_state = S_RD_GAP;
                        end else begin
                            n_state = S_ADVANCE;
                        end
                    end
                    default: n_state = S_RESULT;
                endcase
            end
            S_RD_GAP:     n_state = S_GAP_WAIT;
            S_GAP_WAIT:   n_state = i_stat.rd_zero ? S_ADVANCE : S_RESULT;
            S_ADVANCE:    n_state = S_BOUNDARY;
            S_BOUNDARY:   n_state = i_stat.bound_end ? S_RESULT : S_RD_BURST;
            S_RD_BURST:   n_state = S_BURST_WAIT;
            S_BURST_WAIT: n_state = i_stat.rd_zero ? S_RD_LGAP : S_RESULT;
            S_RD_LGAP:    n_state = S_LGAP_WAIT;
            S_LGAP_WAIT:  n_state = S_RESULT;
            S_RESULT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready   = 1'b1;
                o_ctl.latch = i_s_valid;
            end
            S_EXEC: begin
                case (i_stat.cmd)
                    CMD_WRITE: o_ctl.wr    = 1'b1;
                    CMD_START: o_ctl.start = !i_stat.running;
                    CMD_STOP:  o_ctl.stop  = 1'b1;
                    CMD_TICK:  o_ctl.tick  = i_stat.running && !i_stat.hpl_zero;
                    default: ;
                endcase
            end
            S_RD_GAP: begin
                o_ctl.rd_en  = 1'b1;
                o_ctl.rd_gap = 1'b1;
            end
            S_GAP_WAIT:   o_ctl.set_gap   = 1'b1;
            S_ADVANCE:    o_ctl.advance   = 1'b1;
            S_BOUNDARY:   o_ctl.boundary  = 1'b1;
            S_RD_BURST:   o_ctl.rd_en     = 1'b1;
            S_BURST_WAIT: o_ctl.set_burst = 1'b1;
            S_RD_LGAP: begin
                o_ctl.rd_en  = 1'b1;
                o_ctl.rd_gap = 1'b1;
            end
            S_LGAP_WAIT:  o_ctl.set_gap   = 1'b1;
            S_RESULT:     o_ctl.capture   = i_stat.out_free;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_rd_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.rd_en |=> (r_state == S_GAP_WAIT || r_state == S_BURST_WAIT ||
                         r_state == S_LGAP_WAIT))
        else $error("table read data not consumed one cycle after read");

    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.capture |=> o_s_ready)
        else $error("input not reopened after result capture");
`endif

endmodule

// ===== rtl/core/ir_burst_sequence_transmitter.sv =====
// ----------------------------------------------------------------------------
// ir_burst_sequence_transmitter
// infrared remote transmitter sending a table of burst/gap pairs on a carrier
//
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tuser cmd, tdata entry_index, entry_value
// m_axis    out  m_axis_tvalid/tready   tdata carrier_out, busy_res; tlast finished
// apb       in   psel/penable/pready    five config registers at 4*index
//
// one transaction at a time; write, stop, ignored commands and plain ticks go
// straight to the result, a tick ending a burst reads the gap, a pair boundary
// the next burst and gap, via the single registered read port of the pair table
// result register decouples output stalls from the next input transaction
// synchronous active-low reset; table contents are not cleared
// ----------------------------------------------------------------------------
module ir_burst_sequence_transmitter
    import irbst_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,   // entry_index[7:0], entry_value[23:8]
    input  logic [S_USER_W-1:0]   s_axis_tuser,   // cmd[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata,   // carrier_out[0], busy_res[1]
    output logic                  m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_cfg               cfg;
    t_dp_ctrl           ctl;
    t_dp_stat           stat;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    irbst_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    irbst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    irbst_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .o_stat    (stat),
        .i_cfg     (cfg),
        .i_s_data  (s_axis_tdata),
        .i_s_user  (s_axis_tuser),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata),
        .o_m_last  (m_axis_tlast),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    irbst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_ctl     (ctl)
    );

endmodule
